// ===== hw/rtl/timed_event_priority_queue_unit_macros.svh =====
// Assertion macros used by the checker file of the timed event queue.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TEPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timed event queue check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define TEPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timed event queue check failed");

`endif

// ===== hw/rtl/tepq_pkg.sv =====
// Shared types and constants of the timed event priority queue.
package tepq_pkg;

    localparam int TICK_W = 48;
    localparam int LOOK_W = 20;
    localparam logic [LOOK_W-1:0] LOOK_RESET = 20'd1024;
    localparam logic MODE_COLLECT = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_DUE    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT,
        ST_DISP,
        ST_INS,
        ST_POP
    } t_state;

    typedef struct packed {
        logic [TICK_W-1:0] target;
        logic [TICK_W-1:0] disp;
    } t_times;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/timed_event_priority_queue_unit.sv =====
// Top level of the timed event priority queue: control, tick pipeline, cell chain.
//
//  channel  | direction | tdata fields (low to high)                  | tuser | tlast
//  s_axis   | in        | tag, lookahead, delay, tbase, dbase, now     | mode  | -
//  m_axis   | out       | tag, target, dispatch, new_earliest, count   | kind  | last
//  cfg      | in        | lookahead samples (i_cfg_wdata)              | -     | -
//
//  Push: result word registered after the input registers, two tick stages and the insert step.
//  Collect: one due event popped per cycle while the output is not stalled, or a single nothing-due word.
//  One item at a time; the next item is accepted once the last result is registered.
//  Reset clears the event count and control; held events need no clearing.
//  A stalled output holds its word and stops the insert or pop step.
module timed_event_priority_queue_unit import tepq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int BATCH_LIMIT = 64,
    parameter int TAG_BITS    = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [LOOK_W-1:0]      i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tag, lookahead flag, delay, target base, dispatch base, current time
    input  logic [((TAG_BITS+1+4*TICK_W+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tag, target, dispatch, new_earliest, queue_count
    output logic [((TAG_BITS+2*TICK_W+1+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // kind
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int BAT_W    = $clog2(BATCH_LIMIT + 1);
    localparam int OUT_W    = ((TAG_BITS + 2*TICK_W + 1 + CNT_W + 7) / 8) * 8;
    localparam int LOOK_POS = TAG_BITS;
    localparam int DLY_LO   = TAG_BITS + 1;
    localparam int TB_LO    = DLY_LO + TICK_W;
    localparam int DB_LO    = TB_LO + TICK_W;
    localparam int NOW_LO   = DB_LO + TICK_W;

    t_state              r_state;
    t_state              n_state;
    logic [LOOK_W-1:0]   r_lookahead;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [BAT_W-1:0]    r_popped;
    logic [BAT_W-1:0]    n_popped;

    logic [TAG_BITS-1:0] r_tag;
    logic                r_look;
    logic [TICK_W-1:0]   r_delay;
    logic [TICK_W-1:0]   r_tbase;
    logic [TICK_W-1:0]   r_dbase;
    logic [TICK_W-1:0]   r_now;

    logic                r_ovalid;
    t_kind               r_o_kind;
    logic [TAG_BITS-1:0] r_o_tag;
    t_times              r_o_times;
    logic                r_o_ne;
    logic [CNT_W-1:0]    r_o_count;
    logic                r_o_last;

    logic                emit;
    t_kind               e_kind;
    logic [TAG_BITS-1:0] e_tag;
    t_times              e_times;
    logic                e_ne;
    logic [CNT_W-1:0]    e_count;
    logic                e_last;

    t_times              tick;
    t_cell_cmd           cell_cmd;
    logic [TICK_W-1:0]   cell_key;
    logic                accept;
    logic                out_free;
    logic                full;
    logic                due0;
    logic                due1;
    logic                pop_last;
    logic                head_eq;

    logic [TAG_BITS-1:0] c_tag   [QUEUE_DEPTH];
    t_times              c_times [QUEUE_DEPTH];
    logic                c_mark  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] l_tag   [QUEUE_DEPTH];
    t_times              l_times [QUEUE_DEPTH];
    logic                l_mark  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] rt_tag  [QUEUE_DEPTH];
    t_times              rt_times[QUEUE_DEPTH];
    logic                occ     [QUEUE_DEPTH];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign full          = (r_count == CNT_W'(QUEUE_DEPTH));
    assign due0          = !c_mark[0];
    assign due1          = !c_mark[1];
    assign pop_last      = !due1 || (r_popped == BAT_W'(BATCH_LIMIT - 1));
    assign head_eq       = (c_times[0].disp == tick.disp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead <= LOOK_RESET;
        end else if (i_cfg_we) begin
            r_lookahead <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag   <= s_axis_tdata[TAG_BITS-1:0];
            r_look  <= s_axis_tdata[LOOK_POS];
            r_delay <= s_axis_tdata[DLY_LO +: TICK_W];
            r_tbase <= s_axis_tdata[TB_LO +: TICK_W];
            r_dbase <= s_axis_tdata[DB_LO +: TICK_W];
            r_now   <= s_axis_tdata[NOW_LO +: TICK_W];
        end
    end

    tepq_tick u_tick (
        .i_clk       (i_clk),
        .i_look      (r_look),
        .i_delay     (r_delay),
        .i_tbase     (r_tbase),
        .i_dbase     (r_dbase),
        .i_lookahead (r_lookahead),
        .o_times     (tick)
    );

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        assign occ[gi] = (r_count > CNT_W'(gi));

        if (gi == 0) begin : g_head
            assign l_tag[gi]   = r_tag;
            assign l_times[gi] = tick;
            assign l_mark[gi]  = 1'b0;
        end else begin : g_body
            assign l_tag[gi]   = c_tag[gi-1];
            assign l_times[gi] = c_times[gi-1];
            assign l_mark[gi]  = c_mark[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign rt_tag[gi]   = c_tag[gi];
            assign rt_times[gi] = c_times[gi];
        end else begin : g_link
            assign rt_tag[gi]   = c_tag[gi+1];
            assign rt_times[gi] = c_times[gi+1];
        end

        tepq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cell_cmd),
            .i_key         (cell_key),
            .i_occ         (occ[gi]),
            .i_new_tag     (r_tag),
            .i_new_times   (tick),
            .i_left_tag    (l_tag[gi]),
            .i_left_times  (l_times[gi]),
            .i_left_mark   (l_mark[gi]),
            .i_right_tag   (rt_tag[gi]),
            .i_right_times (rt_times[gi]),
            .o_tag         (c_tag[gi]),
            .o_times       (c_times[gi]),
            .o_mark        (c_mark[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == MODE_COLLECT) ? ST_POP : ST_TGT;
                end
            end
            ST_TGT:  n_state = ST_DISP;
            ST_DISP: n_state = ST_INS;
            ST_INS: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_free && (!due0 || pop_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        emit     = 1'b0;
        e_kind   = KIND_NONE;
        e_tag    = '0;
        e_times  = '0;
        e_ne     = 1'b0;
        e_count  = r_count;
        e_last   = 1'b0;
        cell_cmd = '0;
        cell_key = tick.disp;
        n_count  = r_count;
        n_popped = r_popped;
        unique case (r_state)
            ST_IDLE: begin
                n_popped = '0;
            end
            ST_INS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_tag   = r_tag;
                    e_times = tick;
                    e_last  = 1'b1;
                    if (full) begin
                        e_kind = KIND_FULL;
                    end else begin
                        e_kind       = KIND_ACCEPT;
                        cell_cmd.ins = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        e_count      = n_count;
                        e_ne         = c_mark[0] || head_eq;
                    end
                end
            end
            ST_POP: begin
                cell_key = r_now;
                if (out_free) begin
                    emit = 1'b1;
                    if (due0) begin
                        e_kind       = KIND_DUE;
                        e_tag        = c_tag[0];
                        e_times      = c_times[0];
                        cell_cmd.pop = 1'b1;
                        n_count      = r_count - CNT_W'(1);
                        e_count      = n_count;
                        e_last       = pop_last;
                        n_popped     = r_popped + BAT_W'(1);
                    end else begin
                        e_last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_popped <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_popped <= n_popped;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind  <= e_kind;
            r_o_tag   <= e_tag;
            r_o_times <= e_times;
            r_o_ne    <= e_ne;
            r_o_count <= e_count;
            r_o_last  <= e_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = OUT_W'({r_o_count, r_o_ne, r_o_times.disp,
                                   r_o_times.target, r_o_tag});

endmodule

// ===== hw/rtl/tepq_tick.sv =====
// Two-stage computation of the target and dispatch ticks of a pushed event.
module tepq_tick import tepq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_look,
    input  logic [TICK_W-1:0] i_delay,
    input  logic [TICK_W-1:0] i_tbase,
    input  logic [TICK_W-1:0] i_dbase,
    input  logic [LOOK_W-1:0] i_lookahead,
    output t_times            o_times
);

    logic [TICK_W:0]   n_sum;
    logic [TICK_W-1:0] r_target;
    logic [TICK_W:0]   r_dl;
    logic [TICK_W-1:0] r_dbase;
    logic [LOOK_W-1:0] r_la;
    logic              r_look;
    t_times            r_times;
    t_times            n_times;

    assign n_sum = {1'b0, i_tbase} + {1'b0, i_delay};

    always_ff @(posedge i_clk) begin
        r_target <= n_sum[TICK_W] ? {TICK_W{1'b1}} : n_sum[TICK_W-1:0];
        r_dl     <= {1'b0, i_dbase} + {{(TICK_W+1-LOOK_W){1'b0}}, i_lookahead};
        r_dbase  <= i_dbase;
        r_la     <= i_lookahead;
        r_look   <= i_look;
    end

    always_comb begin
        n_times.target = r_target;
        if (!r_look) begin
            n_times.disp = r_target;
        end else if ({1'b0, r_target} <= r_dl) begin
            n_times.disp = r_dbase;
        end else begin
            n_times.disp = r_target - {{(TICK_W-LOOK_W){1'b0}}, r_la};
        end
    end

    always_ff @(posedge i_clk) begin
        r_times <= n_times;
    end

    assign o_times = r_times;

endmodule

// ===== hw/rtl/tepq_cell.sv =====
// One slot of the sorted event chain: holds an event, shifts on insert or pop.
module tepq_cell import tepq_pkg::*; #(
    parameter int TAG_BITS = 16
) (
    input  logic                i_clk,
    input  t_cell_cmd           i_cmd,
    input  logic [TICK_W-1:0]   i_key,
    input  logic                i_occ,
    input  logic [TAG_BITS-1:0] i_new_tag,
    input  t_times              i_new_times,
    input  logic [TAG_BITS-1:0] i_left_tag,
    input  t_times              i_left_times,
    input  logic                i_left_mark,
    input  logic [TAG_BITS-1:0] i_right_tag,
    input  t_times              i_right_times,
    output logic [TAG_BITS-1:0] o_tag,
    output t_times              o_times,
    output logic                o_mark
);

    logic [TAG_BITS-1:0] r_tag;
    logic [TAG_BITS-1:0] n_tag;
    t_times              r_times;
    t_times              n_times;

    assign o_mark = !i_occ || (r_times.disp > i_key);

    always_comb begin
        n_tag   = r_tag;
        n_times = r_times;
        priority if (i_cmd.pop) begin
            n_tag   = i_right_tag;
            n_times = i_right_times;
        end else if (i_cmd.ins && i_left_mark) begin
            n_tag   = i_left_tag;
            n_times = i_left_times;
        end else if (i_cmd.ins && o_mark) begin
            n_tag   = i_new_tag;
            n_times = i_new_times;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_times <= n_times;
    end

    assign o_tag   = r_tag;
    assign o_times = r_times;

endmodule

// ===== hw/rtl/tepq_checker.sv =====
// Port-level checks of the timed event priority queue and their bind.
`include "timed_event_priority_queue_unit_macros.svh"

module tepq_checker import tepq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    // tag, target, dispatch, new_earliest, queue_count
    input logic [((TAG_BITS+2*TICK_W+1+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // kind
    input logic [1:0]             m_axis_tuser,
    input logic                   m_axis_tlast
);

    localparam int OUT_W = ((TAG_BITS + 2*TICK_W + 1 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8;

    logic [OUT_W+2:0] out_word;
    logic             push_word;
    logic             none_word;
    logic             none_clear;

    assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign push_word  = m_axis_tvalid &&
                        (m_axis_tuser == KIND_ACCEPT || m_axis_tuser == KIND_FULL);
    assign none_word  = m_axis_tvalid && (m_axis_tuser == KIND_NONE);
    assign none_clear = m_axis_tlast && (m_axis_tdata[TAG_BITS-1:0] == '0);

    `TEPQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_word))
    `TEPQ_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TEPQ_ASSERT_IMP(a_push_last, push_word, m_axis_tlast)
    `TEPQ_ASSERT_IMP(a_none_word, none_word, none_clear)

endmodule

bind timed_event_priority_queue_unit tepq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
) u_tepq_checker (.*);
